### rtl/owtr_pkg.sv
package owtr_pkg;

    localparam int TIMER_BITS_DEF = 18;
    localparam int CFG_W          = 18;
    localparam int CFG_IDX_W      = 3;

    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    localparam logic [9:0]  RST_RESET_LOW     = 10'd500;
    localparam logic [7:0]  RST_RESET_WAIT    = 8'd60;
    localparam logic [7:0]  RST_PRES_TIMEOUT  = 8'd240;
    localparam logic [3:0]  RST_SHORT_LOW     = 4'd2;
    localparam logic [6:0]  RST_LONG_LOW      = 7'd60;
    localparam logic [4:0]  RST_SAMPLE_DELAY  = 5'd8;
    localparam logic [6:0]  RST_READ_RECOVERY = 7'd50;
    localparam logic [17:0] RST_CONVERT_WAIT  = 18'd200000;

    typedef enum logic [3:0] {
        P_IDLE,
        P_RST_LOW,
        P_RST_WAIT,
        P_PRES_LOW,
        P_PRES_HIGH,
        P_WR_LOW,
        P_WR_REL,
        P_CONVERT,
        P_RD_LOW,
        P_RD_WAIT,
        P_RD_REC
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW,
        CFG_RESET_WAIT,
        CFG_PRES_TIMEOUT,
        CFG_SHORT_LOW,
        CFG_LONG_LOW,
        CFG_SAMPLE_DELAY,
        CFG_READ_RECOVERY,
        CFG_CONVERT_WAIT
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]  reset_low;
        logic [7:0]  reset_wait;
        logic [7:0]  pres_timeout;
        logic [3:0]  short_low;
        logic [6:0]  long_low;
        logic [4:0]  sample_delay;
        logic [6:0]  read_recovery;
        logic [17:0] convert_wait;
    } t_cfg;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               no_presence;
        logic signed [15:0] temperature;
    } t_result;

    // command sequence: skip ROM, convert, skip ROM, read scratchpad
    function automatic logic [7:0] cmd_byte(input logic [1:0] step);
        logic [7:0] b;
        case (step)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCRATCH;
        endcase
        return b;
    endfunction

endpackage

### rtl/owtr_in_if.sv
interface owtr_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

### rtl/owtr_out_if.sv
interface owtr_out_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               no_presence;
    logic signed [15:0] temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output no_presence, output temperature, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input no_presence, input temperature, output ready);
endinterface

### rtl/owtr_cfg.sv
module owtr_cfg
    import owtr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RST_RESET_LOW;
            r_cfg.reset_wait    <= RST_RESET_WAIT;
            r_cfg.pres_timeout  <= RST_PRES_TIMEOUT;
            r_cfg.short_low     <= RST_SHORT_LOW;
            r_cfg.long_low      <= RST_LONG_LOW;
            r_cfg.sample_delay  <= RST_SAMPLE_DELAY;
            r_cfg.read_recovery <= RST_READ_RECOVERY;
            r_cfg.convert_wait  <= RST_CONVERT_WAIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data[9:0];
                CFG_RESET_WAIT:    r_cfg.reset_wait    <= i_cfg_data[7:0];
                CFG_PRES_TIMEOUT:  r_cfg.pres_timeout  <= i_cfg_data[7:0];
                CFG_SHORT_LOW:     r_cfg.short_low     <= i_cfg_data[3:0];
                CFG_LONG_LOW:      r_cfg.long_low      <= i_cfg_data[6:0];
                CFG_SAMPLE_DELAY:  r_cfg.sample_delay  <= i_cfg_data[4:0];
                CFG_READ_RECOVERY: r_cfg.read_recovery <= i_cfg_data[6:0];
                CFG_CONVERT_WAIT:  r_cfg.convert_wait  <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/owtr_seq.sv
module owtr_seq
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  logic    i_start_req,
    input  logic    i_line_level,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int CMP_W = (TIMER_BITS + 1 > CFG_W) ? TIMER_BITS + 1 : CFG_W;

    // duration of a timed phase: zero means one tick, clipped to timer max
    function automatic logic [CMP_W-1:0] span(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] tmax;
        ve   = CMP_W'(v);
        tmax = (CMP_W'(1) << TIMER_BITS) - CMP_W'(1);
        if (v == '0) ve = CMP_W'(1);
        if (ve > tmax) ve = tmax;
        return ve;
    endfunction

    t_phase                r_phase,  n_phase;
    logic [TIMER_BITS-1:0] r_timer,  n_timer;
    logic [2:0]            r_bitpos, n_bitpos;
    logic [2:0]            r_bytes,  n_bytes;
    logic [7:0]            r_shift,  n_shift;
    logic [7:0]            r_low,    n_low;
    logic [15:0]           r_temp,   n_temp;
    logic                  r_err,    n_err;
    logic                  r_valid;
    t_result               r_res,    n_res;

    logic             fire;
    logic             drive;
    logic             done;
    logic             seen;
    logic [CFG_W-1:0] t_sel;
    logic [CMP_W-1:0] t_inc;
    logic             t_done;
    logic [TIMER_BITS-1:0] t_next;

    assign o_ready = !r_valid || i_res_ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_bitpos = r_bitpos;
        n_bytes  = r_bytes;
        n_shift  = r_shift;
        n_low    = r_low;
        n_temp   = r_temp;
        n_err    = r_err;
        drive    = 1'b0;
        done     = 1'b0;
        seen     = 1'b0;

        if (r_phase == P_IDLE && i_start_req) begin
            n_phase  = P_RST_LOW;
            n_timer  = '0;
            n_bytes  = '0;
            n_bitpos = '0;
        end

        case (n_phase)
            P_RST_LOW:  t_sel = CFG_W'(i_cfg.reset_low);
            P_RST_WAIT: t_sel = CFG_W'(i_cfg.reset_wait);
            P_WR_LOW:   t_sel = n_shift[0] ? CFG_W'(i_cfg.short_low) : CFG_W'(i_cfg.long_low);
            P_WR_REL:   t_sel = n_shift[0] ? CFG_W'(i_cfg.long_low) : CFG_W'(i_cfg.short_low);
            P_CONVERT:  t_sel = i_cfg.convert_wait;
            P_RD_LOW:   t_sel = CFG_W'(i_cfg.short_low);
            P_RD_WAIT:  t_sel = CFG_W'(i_cfg.sample_delay);
            P_RD_REC:   t_sel = CFG_W'(i_cfg.read_recovery);
            default:    t_sel = CFG_W'(i_cfg.pres_timeout);
        endcase
        t_inc  = CMP_W'(n_timer) + CMP_W'(1);
        t_done = t_inc >= span(t_sel);
        // timer stays below the span, so the increment fits when not done
        t_next = t_done ? '0 : t_inc[TIMER_BITS-1:0];

        case (n_phase)
            P_IDLE: ;
            P_RST_LOW: begin
                drive   = 1'b1;
                n_timer = t_next;
                if (t_done) n_phase = P_RST_WAIT;
            end
            P_RST_WAIT: begin
                n_timer = t_next;
                if (t_done) n_phase = P_PRES_LOW;
            end
            P_PRES_LOW, P_PRES_HIGH: begin
                seen = (n_phase == P_PRES_LOW) ? !i_line_level : i_line_level;
                if (seen && CMP_W'(n_timer) < CMP_W'(i_cfg.pres_timeout)) begin
                    n_timer = '0;
                    if (n_phase == P_PRES_LOW) begin
                        n_phase = P_PRES_HIGH;
                    end else begin
                        n_shift  = cmd_byte(n_bytes[1:0]);
                        n_bitpos = '0;
                        n_phase  = P_WR_LOW;
                    end
                end else if (t_inc >= CMP_W'(i_cfg.pres_timeout)) begin
                    n_phase = P_IDLE;
                    n_err   = 1'b1;
                    done    = 1'b1;
                    n_timer = '0;
                end else begin
                    n_timer = t_inc[TIMER_BITS-1:0];
                end
            end
            P_WR_LOW: begin
                drive   = 1'b1;
                n_timer = t_next;
                if (t_done) n_phase = P_WR_REL;
            end
            P_WR_REL: begin
                n_timer = t_next;
                if (t_done) begin
                    n_shift  = {1'b0, n_shift[7:1]};
                    n_bitpos = n_bitpos + 3'd1;
                    if (n_bitpos != '0) begin
                        n_phase = P_WR_LOW;
                    end else begin
                        n_bytes = n_bytes + 3'd1;
                        if (n_bytes == 3'd2) begin
                            n_phase = P_CONVERT;
                        end else if (n_bytes >= 3'd4) begin
                            n_bytes = 3'd4;
                            n_shift = '0;
                            n_phase = P_RD_LOW;
                        end else begin
                            n_shift = cmd_byte(n_bytes[1:0]);
                            n_phase = P_WR_LOW;
                        end
                    end
                end
            end
            P_CONVERT: begin
                n_timer = t_next;
                if (t_done) n_phase = P_RST_LOW;
            end
            P_RD_LOW: begin
                drive   = 1'b1;
                n_timer = t_next;
                if (t_done) n_phase = P_RD_WAIT;
            end
            P_RD_WAIT: begin
                n_timer = t_next;
                if (t_done) n_phase = P_RD_REC;
            end
            P_RD_REC: begin
                // sample on the first recovery tick, LSB first
                if (n_timer == '0) n_shift = {i_line_level, n_shift[7:1]};
                n_timer = t_next;
                if (t_done) begin
                    n_bitpos = n_bitpos + 3'd1;
                    if (n_bitpos != '0) begin
                        n_phase = P_RD_LOW;
                    end else if (n_bytes == 3'd4) begin
                        n_low   = n_shift;
                        n_shift = '0;
                        n_bytes = 3'd5;
                        n_phase = P_RD_LOW;
                    end else begin
                        n_temp  = {n_shift, n_low};
                        n_phase = P_IDLE;
                        n_err   = 1'b0;
                        done    = 1'b1;
                        n_timer = '0;
                    end
                end
            end
            default: begin
                n_phase = P_IDLE;
                n_timer = '0;
            end
        endcase

        n_res.drive_low   = drive && !done;
        n_res.busy_res    = (n_phase != P_IDLE);
        n_res.done_res    = done;
        n_res.no_presence = n_err;
        n_res.temperature = signed'(n_temp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_IDLE;
            r_timer  <= '0;
            r_bitpos <= '0;
            r_bytes  <= '0;
            r_shift  <= '0;
            r_low    <= '0;
            r_temp   <= '0;
            r_err    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_phase  <= n_phase;
                r_timer  <= n_timer;
                r_bitpos <= n_bitpos;
                r_bytes  <= n_bytes;
                r_shift  <= n_shift;
                r_low    <= n_low;
                r_temp   <= n_temp;
                r_err    <= n_err;
                r_valid  <= 1'b1;
            end else if (i_res_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/onewire_temperature_reader.sv
// An accepted input beat reaches its result beat through the input register,
// then the sequencer step into the result register.
// Throughput: one tick beat per cycle; each stage holds while the next is stalled.
// Reset (i_rst_n low, synchronous): sequencer idle, counters and temperature zero,
// configuration registers back to their default timings, both stages empty.
module onewire_temperature_reader
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    owtr_in_if.sink              i_in,
    owtr_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    logic    seq_ready;
    logic    r_in_valid;
    logic    r_in_start;
    logic    r_in_line;
    logic    in_ready;

    assign in_ready   = !r_in_valid || seq_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_start <= i_in.start_req;
            r_in_line  <= i_in.line_level;
        end
    end

    owtr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owtr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (r_in_valid),
        .i_start_req  (r_in_start),
        .i_line_level (r_in_line),
        .o_ready      (seq_ready),
        .o_valid      (o_out.valid),
        .o_res        (res),
        .i_res_ready  (o_out.ready)
    );

    assign o_out.drive_low   = res.drive_low;
    assign o_out.busy_res    = res.busy_res;
    assign o_out.done_res    = res.done_res;
    assign o_out.no_presence = res.no_presence;
    assign o_out.temperature = res.temperature;

endmodule

### tb/onewire_temperature_reader_checker.sv
module onewire_temperature_reader_checker
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    owtr_in_if                   i_tick,
    owtr_out_if                  i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_runs_ok,
    output int                   o_runs_failed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] COMMAND_SEQ [4] = '{CMD_SKIP_ROM, CMD_CONVERT,
                                               CMD_SKIP_ROM, CMD_READ_SCRATCH};

    // shadow of the sequencer
    t_cfg        timing;
    t_phase      seq_phase;
    int unsigned tick_cnt;
    logic [2:0]  bit_pos;
    logic [2:0]  byte_idx;
    logic [7:0]  shifter;
    logic [7:0]  lsb_byte;
    logic [15:0] temp_q;
    logic        err_q;

    t_result predicted_outputs[$];
    int      mismatch_count;
    int      reads_done;
    int      presence_lost;

    assign o_errors      = mismatch_count;
    assign o_runs_ok     = reads_done;
    assign o_runs_failed = presence_lost;

    function automatic int unsigned span_of(input int unsigned v);
        longint unsigned top_val;
        top_val = (64'd1 << TIMER_BITS) - 1;
        if (v == 0) v = 1;
        if (longint'(v) > top_val) v = top_val[31:0];
        return v;
    endfunction

    // advances the slot timer, true on the last tick of the slot
    function automatic bit slot_over(input int unsigned limit);
        tick_cnt++;
        if (tick_cnt >= span_of(limit)) begin
            tick_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result sequencer_tick(input logic start, input logic line);
        t_result r;
        logic    drive;
        logic    ended;
        logic    seen;
        drive = 1'b0;
        ended = 1'b0;
        if (seq_phase == P_IDLE && start) begin
            seq_phase = P_RST_LOW;
            tick_cnt  = 0;
            byte_idx  = '0;
            bit_pos   = '0;
        end
        case (seq_phase)
            P_IDLE: ;
            P_RST_LOW: begin
                drive = 1'b1;
                if (slot_over(32'(timing.reset_low))) seq_phase = P_RST_WAIT;
            end
            P_RST_WAIT: begin
                if (slot_over(32'(timing.reset_wait))) seq_phase = P_PRES_LOW;
            end
            P_PRES_LOW, P_PRES_HIGH: begin
                seen = (seq_phase == P_PRES_LOW) ? !line : line;
                if (seen && tick_cnt < 32'(timing.pres_timeout)) begin
                    tick_cnt = 0;
                    if (seq_phase == P_PRES_LOW) begin
                        seq_phase = P_PRES_HIGH;
                    end else begin
                        shifter   = COMMAND_SEQ[byte_idx[1:0]];
                        bit_pos   = '0;
                        seq_phase = P_WR_LOW;
                    end
                end else begin
                    tick_cnt++;
                    if (tick_cnt >= 32'(timing.pres_timeout)) begin
                        seq_phase = P_IDLE;
                        err_q     = 1'b1;
                        ended     = 1'b1;
                        tick_cnt  = 0;
                    end
                end
            end
            P_WR_LOW: begin
                drive = 1'b1;
                if (slot_over(shifter[0] ? 32'(timing.short_low) : 32'(timing.long_low)))
                    seq_phase = P_WR_REL;
            end
            P_WR_REL: begin
                if (slot_over(shifter[0] ? 32'(timing.long_low)
                                         : 32'(timing.short_low))) begin
                    shifter = shifter >> 1;
                    bit_pos++;
                    if (bit_pos != 0) begin
                        seq_phase = P_WR_LOW;
                    end else begin
                        byte_idx++;
                        if (byte_idx == 3'd2) begin
                            seq_phase = P_CONVERT;
                        end else if (byte_idx >= 3'd4) begin
                            byte_idx  = 3'd4;
                            shifter   = '0;
                            seq_phase = P_RD_LOW;
                        end else begin
                            shifter   = COMMAND_SEQ[byte_idx[1:0]];
                            seq_phase = P_WR_LOW;
                        end
                    end
                end
            end
            P_CONVERT: begin
                if (slot_over(32'(timing.convert_wait))) seq_phase = P_RST_LOW;
            end
            P_RD_LOW: begin
                drive = 1'b1;
                if (slot_over(32'(timing.short_low))) seq_phase = P_RD_WAIT;
            end
            P_RD_WAIT: begin
                if (slot_over(32'(timing.sample_delay))) seq_phase = P_RD_REC;
            end
            P_RD_REC: begin
                // bit is sampled on the first recovery tick
                if (tick_cnt == 0) shifter = {line, shifter[7:1]};
                if (slot_over(32'(timing.read_recovery))) begin
                    bit_pos++;
                    if (bit_pos != 0) begin
                        seq_phase = P_RD_LOW;
                    end else if (byte_idx == 3'd4) begin
                        lsb_byte  = shifter;
                        shifter   = '0;
                        byte_idx  = 3'd5;
                        seq_phase = P_RD_LOW;
                    end else begin
                        temp_q    = {shifter, lsb_byte};
                        seq_phase = P_IDLE;
                        err_q     = 1'b0;
                        ended     = 1'b1;
                        tick_cnt  = 0;
                    end
                end
            end
            default: begin
                seq_phase = P_IDLE;
                tick_cnt  = 0;
            end
        endcase
        r.drive_low   = ended ? 1'b0 : drive;
        r.busy_res    = (seq_phase != P_IDLE);
        r.done_res    = ended;
        r.no_presence = err_q;
        r.temperature = temp_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            timing.reset_low     = RST_RESET_LOW;
            timing.reset_wait    = RST_RESET_WAIT;
            timing.pres_timeout  = RST_PRES_TIMEOUT;
            timing.short_low     = RST_SHORT_LOW;
            timing.long_low      = RST_LONG_LOW;
            timing.sample_delay  = RST_SAMPLE_DELAY;
            timing.read_recovery = RST_READ_RECOVERY;
            timing.convert_wait  = RST_CONVERT_WAIT;
            seq_phase = P_IDLE;
            tick_cnt  = 0;
            bit_pos   = '0;
            byte_idx  = '0;
            shifter   = '0;
            lsb_byte  = '0;
            temp_q    = '0;
            err_q     = 1'b0;
            predicted_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RESET_LOW:     timing.reset_low     = i_cfg_data[9:0];
                    CFG_RESET_WAIT:    timing.reset_wait    = i_cfg_data[7:0];
                    CFG_PRES_TIMEOUT:  timing.pres_timeout  = i_cfg_data[7:0];
                    CFG_SHORT_LOW:     timing.short_low     = i_cfg_data[3:0];
                    CFG_LONG_LOW:      timing.long_low      = i_cfg_data[6:0];
                    CFG_SAMPLE_DELAY:  timing.sample_delay  = i_cfg_data[4:0];
                    CFG_READ_RECOVERY: timing.read_recovery = i_cfg_data[6:0];
                    default:           timing.convert_wait  = i_cfg_data[17:0];
                endcase
            end
            if (i_tick.valid && i_tick.ready) begin
                want = sequencer_tick(i_tick.start_req, i_tick.line_level);
                if (want.done_res) begin
                    if (want.no_presence) presence_lost++;
                    else reads_done++;
                end
                predicted_outputs.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                if (predicted_outputs.size() == 0) begin
                    $error("result beat with no tick waiting for it");
                    mismatch_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (i_res.drive_low !== want.drive_low) begin
                        $error("drive_low: expected %0d, got %0d",
                               want.drive_low, i_res.drive_low);
                        mismatch_count++;
                    end
                    if (i_res.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, i_res.busy_res);
                        mismatch_count++;
                    end
                    if (i_res.done_res !== want.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               want.done_res, i_res.done_res);
                        mismatch_count++;
                    end
                    if (i_res.no_presence !== want.no_presence) begin
                        $error("no_presence: expected %0d, got %0d",
                               want.no_presence, i_res.no_presence);
                        mismatch_count++;
                    end
                    if (i_res.temperature !== want.temperature) begin
                        $error("temperature: expected %0d, got %0d",
                               want.temperature, i_res.temperature);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= predicted_outputs.size();
    end

endmodule

### tb/onewire_temperature_reader_test.sv
module onewire_temperature_reader_test;
    import owtr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatches;
    int pending;
    int runs_ok;
    int runs_failed;
    int tx_idle_pct;
    int rx_idle_pct;
    int beats_sent;
    int drain_stuck;
    int stall_left;
    bit stall_done;
    t_cfg cur;

    owtr_in_if  tick_in ();
    owtr_out_if tick_out ();

    onewire_temperature_reader uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_in),
        .o_out      (tick_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    onewire_temperature_reader_checker temp_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick_in),
        .i_res         (tick_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_pending     (pending),
        .o_runs_ok     (runs_ok),
        .o_runs_failed (runs_failed)
    );

    always #6 i_clk = ~i_clk;

    // result side: random stalls plus one long hold-off that backs up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_out.ready <= 1'b0;
        end else if (stall_left != 0) begin
            tick_out.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if (!stall_done && beats_sent >= 60) begin
            tick_out.ready <= 1'b0;
            stall_left     <= 100;
            stall_done     <= 1'b1;
        end else begin
            tick_out.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_tick(input logic start, input logic line);
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_in.valid      <= 1'b1;
        tick_in.start_req  <= start;
        tick_in.line_level <= line;
        @(posedge i_clk);
        while (!tick_in.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // line level comes in chunks: fair coin, mostly high or mostly low
    task automatic run_ticks(input int n, input int start_pct, input bit line_high);
        int   mode;
        logic line;
        mode = 0;
        for (int k = 0; k < n; k++) begin
            if (k % 32 == 0) mode = $urandom_range(2);
            case (mode)
                0:       line = 1'($urandom_range(1));
                1:       line = ($urandom_range(19) != 0);
                default: line = ($urandom_range(19) == 0);
            endcase
            send_tick($urandom_range(99) < start_pct, line | line_high);
        end
    endtask

    // drop valid and wait until every tick beat has its result
    task automatic settle();
        int guard;
        tick_in.valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending != 0) drain_stuck++;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_timing(input t_cfg c);
        settle();
        write_reg(CFG_RESET_LOW,     CFG_W'(c.reset_low));
        write_reg(CFG_RESET_WAIT,    CFG_W'(c.reset_wait));
        write_reg(CFG_PRES_TIMEOUT,  CFG_W'(c.pres_timeout));
        write_reg(CFG_SHORT_LOW,     CFG_W'(c.short_low));
        write_reg(CFG_LONG_LOW,      CFG_W'(c.long_low));
        write_reg(CFG_SAMPLE_DELAY,  CFG_W'(c.sample_delay));
        write_reg(CFG_READ_RECOVERY, CFG_W'(c.read_recovery));
        write_reg(CFG_CONVERT_WAIT,  CFG_W'(c.convert_wait));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        tick_in.valid      = 1'b0;
        tick_in.start_req  = 1'b0;
        tick_in.line_level = 1'b1;
        tick_out.ready     = 1'b0;
        beats_sent         = 0;
        drain_stuck        = 0;
        stall_left         = 0;
        stall_done         = 1'b0;
        tx_idle_pct        = 8;
        rx_idle_pct        = 55;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every duration zero, presence timeout zero: fails on first presence tick
        cur = '0;
        load_timing(cur);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);  // start while busy is dropped
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);

        // timeout of one: lose the release, then lose the pulse itself
        cur.pres_timeout = 8'd1;
        load_timing(cur);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);

        // short random timings across the three idling regimes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 55;
                end
                1: begin
                    tx_idle_pct = 55;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            cur.reset_low     = 10'($urandom_range(6));
            cur.reset_wait    = 8'($urandom_range(4));
            cur.pres_timeout  = ($urandom_range(7) == 0) ? 8'($urandom_range(1))
                                                         : 8'($urandom_range(20, 3));
            cur.short_low     = 4'($urandom_range(2));
            cur.long_low      = 7'($urandom_range(3));
            cur.sample_delay  = 5'($urandom_range(2));
            cur.read_recovery = 7'($urandom_range(2));
            cur.convert_wait  = 18'($urandom_range(8));
            load_timing(cur);
            run_ticks(60, 8, 1'b0);
        end
        // line held high, no start: whatever run is open ends before the long timings
        run_ticks(150, 0, 1'b1);

        // long reset and wait, longest conversion setting; no device answers
        cur.reset_low     = 10'd20;
        cur.reset_wait    = 8'd20;
        cur.pres_timeout  = 8'd60;
        cur.short_low     = '0;
        cur.long_low      = '0;
        cur.sample_delay  = '0;
        cur.read_recovery = '0;
        cur.convert_wait  = '1;
        load_timing(cur);
        run_ticks(1, 100, 1'b1);
        run_ticks(105, 0, 1'b1);

        // longest slot timings, first slots only
        cur.reset_low     = '0;
        cur.reset_wait    = '0;
        cur.short_low     = '1;
        cur.long_low      = '1;
        cur.sample_delay  = '1;
        cur.read_recovery = '1;
        cur.convert_wait  = '0;
        load_timing(cur);
        run_ticks(1, 100, 1'b0);
        run_ticks(119, 0, 1'b0);

        settle();
        $display("Ran %0d tick beats over zero, short random and long timings",
                 beats_sent);
        $display("%0d reads completed, %0d runs ended without presence",
                 runs_ok, runs_failed);
        if (mismatches == 0 && drain_stuck == 0) begin
            $display("onewire_temperature_reader: match");
        end else begin
            $display("onewire_temperature_reader: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("onewire_temperature_reader: mismatch");
        $finish;
    end

endmodule

### onewire_temperature_reader.f
rtl/owtr_pkg.sv
rtl/owtr_in_if.sv
rtl/owtr_out_if.sv
rtl/owtr_cfg.sv
rtl/owtr_seq.sv
rtl/onewire_temperature_reader.sv
tb/onewire_temperature_reader_checker.sv
tb/onewire_temperature_reader_test.sv
